/* rtl/core/trq_pkg.sv */
// types and constants shared by the timed release queue
package trq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_DROPPED  = 2'd1;
  localparam logic [1:0] KIND_RELEASED = 2'd2;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] delay;
    logic [31:0] deadline;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tag;
    logic [15:0] delay;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

/* rtl/core/trq_if.sv */
// valid/ready channel interfaces for command and result words
interface trq_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] tag;
  logic [15:0] delay_ticks;

  modport source (output valid, output cmd, output tag, output delay_ticks, input ready);
  modport sink (input valid, input cmd, input tag, input delay_ticks, output ready);
endinterface

interface trq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] out_tag;
  logic [15:0] out_delay;
  logic        last;

  modport source (output valid, output kind, output out_tag, output out_delay,
                  output last, input ready);
  modport sink (input valid, input kind, input out_tag, input out_delay,
                input last, output ready);
endinterface

/* rtl/core/timed_release_queue.sv */
// top level of the timed release queue: timer table in ram and scan control
//
// in_ch carries command words: insert (tag, delay_ticks) or tick.
// out_ch carries result words: kind, out_tag, out_delay, last.
// an insert gives one result word, accepted or dropped when full, visible
// in the cycle after the command is taken; the next command can follow at
// once if out_ch.ready is high. a tick advances the 32-bit time count and
// scans the table in order, one entry per cycle through the ram read port
// while the output does not stall, writing kept entries back compacted and
// releasing due ones; in_ch.ready is low during the scan. a tick with nothing
// due gives no result word. the last release of a tick carries last = 1.
// reset empties the table and clears the time count; ram contents are not
// cleared and need no clearing pass.
// when out_ch.ready is low the scan pauses on the next due entry and
// resumes once the output register frees up; no word is lost.
module timed_release_queue import trq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  trq_in_if.sink  in_ch,
  trq_out_if.source out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  state_t      state_r, state_nxt;
  logic [31:0] now_r, now_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [15:0] pend_tag_r, pend_tag_nxt;
  logic [15:0] pend_delay_r, pend_delay_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, cur;
  logic [63:0]   rdata;
  logic          out_load, slot_free;
  result_t       res;
  logic          in_acc;
  logic [31:0]   diff;
  logic          due;

  trq_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  trq_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (out_load),
    .res    (res),
    .free   (slot_free),
    .out_ch (out_ch)
  );

  assign cur         = entry_t'(rdata);
  assign diff        = cur.deadline - now_r;
  assign due         = (diff == 32'd0) || diff[31];
  assign in_ch.ready = (state_r == ST_IDLE) && slot_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    logic consume;
    consume        = 1'b0;
    state_nxt      = state_r;
    now_nxt        = now_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    rd_pend_nxt    = rd_pend_r;
    pend_v_nxt     = pend_v_r;
    pend_tag_nxt   = pend_tag_r;
    pend_delay_nxt = pend_delay_r;
    we             = 1'b0;
    waddr          = '0;
    wdata          = cur;
    re             = 1'b0;
    raddr          = idx_r[AW-1:0];
    out_load       = 1'b0;
    res            = '{kind: KIND_RELEASED, tag: pend_tag_r, delay: pend_delay_r,
                       last: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == CMD_INSERT) begin
            out_load = 1'b1;
            res = '{kind: KIND_ACCEPTED, tag: in_ch.tag, delay: in_ch.delay_ticks,
                    last: 1'b1};
            if (count_r < FULL) begin
              we        = 1'b1;
              waddr     = count_r[AW-1:0];
              wdata     = '{tag: in_ch.tag, delay: in_ch.delay_ticks,
                            deadline: now_r + {16'd0, in_ch.delay_ticks}};
              count_nxt = count_r + 1'b1;
            end else begin
              res.kind = KIND_DROPPED;
            end
          end else begin
            now_nxt     = now_r + 32'd1;
            idx_nxt     = '0;
            keep_nxt    = '0;
            rd_pend_nxt = 1'b0;
            pend_v_nxt  = 1'b0;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_pend_r) begin
          if (due) begin
            if (!pend_v_r || slot_free) begin
              consume        = 1'b1;
              out_load       = pend_v_r;
              pend_v_nxt     = 1'b1;
              pend_tag_nxt   = cur.tag;
              pend_delay_nxt = cur.delay;
            end
          end else begin
            consume  = 1'b1;
            we       = 1'b1;
            waddr    = keep_r[AW-1:0];
            keep_nxt = keep_r + 1'b1;
          end
        end
        if ((idx_r < count_r) && (!rd_pend_r || consume)) begin
          re          = 1'b1;
          idx_nxt     = idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end else if (consume) begin
          rd_pend_nxt = 1'b0;
        end
        if (!rd_pend_r && (idx_r == count_r)) begin
          if (!pend_v_r || slot_free) begin
            out_load   = pend_v_r;
            res.last   = 1'b1;
            pend_v_nxt = 1'b0;
            count_nxt  = keep_r;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      now_r     <= '0;
      count_r   <= '0;
      idx_r     <= '0;
      keep_r    <= '0;
      rd_pend_r <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      now_r     <= now_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      keep_r    <= keep_nxt;
      rd_pend_r <= rd_pend_nxt;
      pend_v_r  <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_tag_r   <= pend_tag_nxt;
    pend_delay_r <= pend_delay_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("entry count above table depth");

  a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (keep_r <= idx_r) && (idx_r <= count_r))
    else $error("compaction index ahead of scan index");

  a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == CMD_TICK) |=> (state_r == ST_SCAN) && (idx_r == '0)
      && (now_r == $past(now_r) + 32'd1))
    else $error("tick did not start a scan");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.cmd == CMD_INSERT && count_r < FULL)
      |=> (count_r == $past(count_r) + 1'b1) && out_ch.valid)
    else $error("insert did not grow the table");

endmodule

/* rtl/core/trq_ram.sv */
// generic single write port, single read port ram with registered read
module trq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/trq_out_reg.sv */
// result output register driving the result channel
module trq_out_reg import trq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  result_t   res,
  output logic      free,
  trq_out_if.source out_ch
);

  logic    valid_r;
  result_t data_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.kind      = data_r.kind;
  assign out_ch.out_tag   = data_r.tag;
  assign out_ch.out_delay = data_r.delay;
  assign out_ch.last      = data_r.last;

endmodule
